// ===== rtl/html_tag_scanner_defines.svh =====
`ifndef HTML_TAG_SCANNER_DEFINES_SVH
`define HTML_TAG_SCANNER_DEFINES_SVH

// Checked property, dropped while reset is high.
`define HSC_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Checked property, also checked during reset.
`define HSC_ASSERT_RST(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

// ===== rtl/hsc_pkg.sv =====
package hsc_pkg;

   localparam logic [1:0] KIND_CHAR = 2'd0;
   localparam logic [1:0] KIND_TAG  = 2'd1;
   localparam logic [1:0] KIND_EOS  = 2'd2;

   localparam logic [1:0] TAG_START = 2'd0;
   localparam logic [1:0] TAG_END   = 2'd1;
   localparam logic [1:0] TAG_VOID  = 2'd2;
   localparam logic [1:0] TAG_ERROR = 2'd3;

   localparam logic [7:0] CHAR_LT    = 8'h3C;
   localparam logic [7:0] CHAR_SLASH = 8'h2F;

   localparam int RSP_DATA_W = 16;

   // One queued token: first result, and whether an end-of-stream beat follows it.
   typedef struct packed {
      logic       eos_after;
      logic [1:0] kind;
      logic [7:0] name_char;
      logic [1:0] tag_kind;
   } entry_type;

   function automatic logic is_name_byte(input logic [7:0] c);
      is_name_byte = (c >= 8'd48 && c <= 8'd57) || (c >= 8'd65 && c <= 8'd90) ||
                     (c >= 8'd97 && c <= 8'd122);
   endfunction

endpackage

// ===== rtl/html_tag_scanner.sv =====
// HTML tag scanner.
// req channel: one beat per input byte; req_tdata[7:0] is the byte, and
//   req_tlast marks end of file (the byte is then ignored).
// rsp channel: zero, one or two beats per input beat. rsp_tuser is the result
//   kind (name char, tag done, end of stream), rsp_tdata carries the name
//   char [7:0] and tag kind [9:8], rsp_tlast flags the last beat of an input.
// A classifier takes one req beat per cycle while the queue has room and
//   pushes at most one token into a QUEUE_DEPTH-entry queue; the emitter
//   expands a token into one or two rsp beats from an output register.
// A req beat's result passes through a queue slot and then the output register.
// Throughput: 1 req beat per cycle while rsp keeps up; end of file inside a
//   name adds an extra rsp beat, the end-of-stream beat.
// Reset clears the scan state, the queue and the output register's valid flag.
// If rsp_tready is low, the output holds; req_tready drops once the queue
//   fills, so no beat is lost.
module html_tag_scanner #(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] data_byte
   input  logic        req_tlast,   // end_of_file
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // [7:0] name_char, [9:8] tag_kind, [15:10] zero
   output logic [1:0]  rsp_tuser,   // [1:0] kind
   output logic        rsp_tlast    // last_of_run
);

   hsc_pkg::entry_type push_entry;
   hsc_pkg::entry_type head;
   logic               push;
   logic               pop;
   logic               q_full;
   logic               q_empty;

   hsc_front u_front (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_tvalid),
      .in_byte    (req_tdata),
      .in_eof     (req_tlast),
      .in_ready   (req_tready),
      .q_full     (q_full),
      .push       (push),
      .push_entry (push_entry)
   );

   hsc_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .full       (q_full),
      .pop        (pop),
      .empty      (q_empty),
      .head       (head)
   );

   hsc_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_empty   (q_empty),
      .q_head    (head),
      .pop       (pop),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_data  (rsp_tdata),
      .out_kind  (rsp_tuser),
      .out_last  (rsp_tlast)
   );

endmodule

// ===== rtl/hsc_front.sv =====
module hsc_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   input  logic [7:0]          in_byte,
   input  logic                in_eof,
   output logic                in_ready,
   input  logic                q_full,
   output logic                push,
   output hsc_pkg::entry_type  push_entry
);

   localparam logic [2:0] MODE_SKIP      = 3'd0;
   localparam logic [2:0] MODE_AFTER_LT  = 3'd1;
   localparam logic [2:0] MODE_END_FIRST = 3'd2;
   localparam logic [2:0] MODE_START_NAM = 3'd3;
   localparam logic [2:0] MODE_END_NAM   = 3'd4;
   localparam logic [2:0] MODE_ERROR     = 3'd5;

   logic [2:0] mode_ff;
   logic [2:0] mode_in;
   logic       emit;
   logic       accept;
   logic       name_b;

   assign in_ready = !q_full;
   assign accept   = in_valid && in_ready;
   assign name_b   = hsc_pkg::is_name_byte(in_byte);
   assign push     = accept && emit;

   always_comb begin
      mode_in              = mode_ff;
      emit                 = 1'b0;
      push_entry.eos_after = 1'b0;
      push_entry.kind      = hsc_pkg::KIND_TAG;
      push_entry.name_char = 8'd0;
      push_entry.tag_kind  = hsc_pkg::TAG_START;
      if (in_eof) begin
         mode_in = MODE_SKIP;
         case (mode_ff)
            MODE_AFTER_LT, MODE_END_FIRST: begin
               emit                = 1'b1;
               push_entry.tag_kind = hsc_pkg::TAG_ERROR;
            end
            MODE_START_NAM: begin
               emit                 = 1'b1;
               push_entry.eos_after = 1'b1;
            end
            MODE_END_NAM: begin
               emit                 = 1'b1;
               push_entry.eos_after = 1'b1;
               push_entry.tag_kind  = hsc_pkg::TAG_END;
            end
            MODE_ERROR: begin
               emit = 1'b0;
            end
            default: begin
               emit            = 1'b1;
               push_entry.kind = hsc_pkg::KIND_EOS;
            end
         endcase
      end else begin
         case (mode_ff)
            MODE_AFTER_LT: begin
               if (in_byte == hsc_pkg::CHAR_SLASH) begin
                  mode_in = MODE_END_FIRST;
               end else if (name_b) begin
                  emit                 = 1'b1;
                  push_entry.kind      = hsc_pkg::KIND_CHAR;
                  push_entry.name_char = in_byte;
                  mode_in              = MODE_START_NAM;
               end else begin
                  emit                = 1'b1;
                  push_entry.tag_kind = hsc_pkg::TAG_ERROR;
                  mode_in             = MODE_ERROR;
               end
            end
            MODE_END_FIRST: begin
               emit = 1'b1;
               if (name_b) begin
                  push_entry.kind      = hsc_pkg::KIND_CHAR;
                  push_entry.name_char = in_byte;
                  mode_in              = MODE_END_NAM;
               end else begin
                  push_entry.tag_kind = hsc_pkg::TAG_ERROR;
                  mode_in             = MODE_ERROR;
               end
            end
            MODE_START_NAM: begin
               emit = 1'b1;
               if (name_b) begin
                  push_entry.kind      = hsc_pkg::KIND_CHAR;
                  push_entry.name_char = in_byte;
               end else begin
                  push_entry.tag_kind = (in_byte == hsc_pkg::CHAR_SLASH) ?
                                        hsc_pkg::TAG_VOID : hsc_pkg::TAG_START;
                  mode_in             = MODE_SKIP;
               end
            end
            MODE_END_NAM: begin
               emit = 1'b1;
               if (name_b) begin
                  push_entry.kind      = hsc_pkg::KIND_CHAR;
                  push_entry.name_char = in_byte;
               end else begin
                  push_entry.tag_kind = hsc_pkg::TAG_END;
                  // ending byte rescanned as text
                  mode_in = (in_byte == hsc_pkg::CHAR_LT) ? MODE_AFTER_LT : MODE_SKIP;
               end
            end
            MODE_ERROR: begin
               emit = 1'b0;
            end
            default: begin
               mode_in = (in_byte == hsc_pkg::CHAR_LT) ? MODE_AFTER_LT : MODE_SKIP;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_SKIP;
      end else if (accept) begin
         mode_ff <= mode_in;
      end
   end

endmodule

// ===== rtl/hsc_queue.sv =====
module hsc_queue #(
   parameter int DEPTH = 4
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  hsc_pkg::entry_type  push_entry,
   output logic                full,
   input  logic                pop,
   output logic                empty,
   output hsc_pkg::entry_type  head
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);
   localparam logic [PW-1:0] LAST_PTR  = PW'(DEPTH - 1);
   localparam logic [CW-1:0] DEPTH_CNT = CW'(DEPTH);

   hsc_pkg::entry_type slot_ff [DEPTH];
   logic [PW-1:0] wr_ptr_ff;
   logic [PW-1:0] rd_ptr_ff;
   logic [CW-1:0] count_ff;
   logic [PW-1:0] wr_ptr_in;
   logic [PW-1:0] rd_ptr_in;
   logic [CW-1:0] count_in;
   logic          do_push;
   logic          do_pop;

   assign full    = (count_ff == DEPTH_CNT);
   assign empty   = (count_ff == '0);
   assign head    = slot_ff[rd_ptr_ff];
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + PW'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + PW'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CW'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

// ===== rtl/hsc_back.sv =====
module hsc_back (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               q_empty,
   input  hsc_pkg::entry_type                 q_head,
   output logic                               pop,
   output logic                               out_valid,
   input  logic                               out_ready,
   output logic [hsc_pkg::RSP_DATA_W-1:0]     out_data,
   output logic [1:0]                         out_kind,
   output logic                               out_last
);

   logic       valid_ff;
   logic       valid_in;
   logic       eos_pend_ff;
   logic       eos_pend_in;
   logic [1:0] kind_ff;
   logic [1:0] kind_in;
   logic [7:0] char_ff;
   logic [7:0] char_in;
   logic [1:0] tag_ff;
   logic [1:0] tag_in;
   logic       last_ff;
   logic       last_in;
   logic       out_free;

   assign out_free = !valid_ff || out_ready;
   assign pop      = out_free && !eos_pend_ff && !q_empty;

   always_comb begin
      valid_in    = valid_ff;
      eos_pend_in = eos_pend_ff;
      kind_in     = kind_ff;
      char_in     = char_ff;
      tag_in      = tag_ff;
      last_in     = last_ff;
      if (out_free) begin
         if (eos_pend_ff) begin
            valid_in    = 1'b1;
            eos_pend_in = 1'b0;
            kind_in     = hsc_pkg::KIND_EOS;
            char_in     = 8'd0;
            tag_in      = 2'd0;
            last_in     = 1'b1;
         end else if (!q_empty) begin
            valid_in    = 1'b1;
            eos_pend_in = q_head.eos_after;
            kind_in     = q_head.kind;
            char_in     = q_head.name_char;
            tag_in      = q_head.tag_kind;
            last_in     = !q_head.eos_after;
         end else begin
            valid_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= 1'b0;
         eos_pend_ff <= 1'b0;
      end else begin
         valid_ff    <= valid_in;
         eos_pend_ff <= eos_pend_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff <= kind_in;
      char_ff <= char_in;
      tag_ff  <= tag_in;
      last_ff <= last_in;
   end

   assign out_valid = valid_ff;
   assign out_kind  = kind_ff;
   assign out_last  = last_ff;
   assign out_data  = {{(hsc_pkg::RSP_DATA_W - 10){1'b0}}, tag_ff, char_ff};

endmodule

// ===== rtl/hsc_checker.sv =====
`include "html_tag_scanner_defines.svh"

module hsc_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [15:0] rsp_tdata,
   input logic [1:0]  rsp_tuser,
   input logic        rsp_tlast
);

   `HSC_ASSERT_RST(a_reset_idle, reset |=> !rsp_tvalid, "rsp valid right after reset")

   `HSC_ASSERT(a_rsp_hold, rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser) && $stable(rsp_tlast), "stalled rsp beat changed")

   `HSC_ASSERT(a_eos_shape, rsp_tvalid && rsp_tuser == hsc_pkg::KIND_EOS |-> rsp_tlast && rsp_tdata == '0, "bad end-of-stream beat")

   `HSC_ASSERT(a_kind_legal, rsp_tvalid |-> rsp_tuser != 2'd3, "undefined rsp kind")

   `HSC_ASSERT(a_tag_then_eos, rsp_tvalid && rsp_tready && rsp_tuser == hsc_pkg::KIND_TAG && !rsp_tlast |=> rsp_tvalid && rsp_tuser == hsc_pkg::KIND_EOS, "tag not followed by end of stream")

endmodule

bind html_tag_scanner hsc_checker u_checker (.*);
